// ===== src/bcu_pkg.sv =====
// Package for the binomial coefficient unit: sizes, derived widths and
// the request and response payload types. No dependencies.
package bcu_pkg;

    localparam int MAX_N        = 63;
    localparam int ACC_WIDTH    = 128;
    localparam int N_WIDTH      = 6;
    localparam int RESULT_WIDTH = 64;

    // n compared against MAX_N with one spare bit so MAX_N up to 127 fits
    localparam int N_CMP_WIDTH  = N_WIDTH + 1;

    // shift-add multiplier: one multiplier bit per cycle
    localparam int MUL_BITS      = N_WIDTH;
    localparam int MUL_CNT_WIDTH = $clog2(MUL_BITS);
    localparam int PROD_WIDTH    = ACC_WIDTH + MUL_BITS;

    // long divider: DIV_RADIX dividend bits per cycle
    localparam int DIV_RADIX     = 8;
    localparam int DIV_CYCLES    = (ACC_WIDTH + DIV_RADIX - 1) / DIV_RADIX;
    localparam int DIV_WIDTH     = DIV_CYCLES * DIV_RADIX;
    localparam int DIV_CNT_WIDTH = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic [N_WIDTH-1:0] n_total;
        logic [N_WIDTH-1:0] k_chosen;
    } req_t;

    typedef struct packed {
        logic [RESULT_WIDTH-1:0] coefficient;
        logic                    overflow;
    } rsp_t;

endpackage

// ===== src/binomial_coefficient_unit.sv =====
// Binomial coefficient unit: one sequencer shares a shift-add multiplier and a
// radix-256 long divider over one accumulator. Depends on bcu_pkg.
// For k > n or n out of range the request goes straight to the finish step; otherwise each of
// the K = min(k, n-k) factors takes a multiply pass and a decision step, with at most 2K division
// trials in all. A new request is taken only after the previous response has been loaded into the
// response register. Reset (rst_n, async, active low) idles and empties the response register.
module binomial_coefficient_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bcu_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bcu_pkg::rsp_t  rsp_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_STEP = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam int NW = bcu_pkg::N_WIDTH;
    localparam int AW = bcu_pkg::ACC_WIDTH;
    localparam int PW = bcu_pkg::PROD_WIDTH;
    localparam int DW = bcu_pkg::DIV_WIDTH;
    localparam int RX = bcu_pkg::DIV_RADIX;

    logic [2:0]                          state_reg, state_next;
    logic [AW-1:0]                       acc_reg, acc_next;
    logic [PW-1:0]                       prod_reg, prod_next;
    logic [DW-1:0]                       work_reg, work_next;
    logic [NW-1:0]                       rem_reg, rem_next;
    logic [NW-1:0]                       i_reg, i_next;
    logic [NW-1:0]                       j_reg, j_next;
    logic [NW-1:0]                       stop_reg, stop_next;
    logic                                ovf_reg, ovf_next;
    logic [bcu_pkg::MUL_CNT_WIDTH-1:0]   mul_bit_reg, mul_bit_next;
    logic [bcu_pkg::DIV_CNT_WIDTH-1:0]   div_cnt_reg, div_cnt_next;
    logic                                rsp_valid_reg, rsp_valid_next;
    bcu_pkg::rsp_t                       rsp_data_reg, rsp_data_next;

    logic          req_xfer;
    logic          rsp_free;
    logic [NW-1:0] k_eff;
    logic [NW-1:0] n_minus_k;
    logic [PW-1:0] prod_sum;
    logic [NW-1:0] rem_step;
    logic [RX-1:0] q_bits;
    logic [DW-1:0] work_shift;
    logic [NW-1:0] j_dec;
    logic          acc_high;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // fold k onto the smaller side
    assign n_minus_k = req_data.n_total - req_data.k_chosen;
    assign k_eff     = (n_minus_k < req_data.k_chosen) ? n_minus_k : req_data.k_chosen;

    // shift-add multiplier: add the accumulator at this bit's weight
    always_comb
    begin
        prod_sum = prod_reg;
        if (i_reg[mul_bit_reg])
        begin
            prod_sum = prod_reg + (PW'(acc_reg) << mul_bit_reg);
        end
    end

    // long divider: retire RX dividend bits into the remainder per cycle
    always_comb
    begin
        logic [NW:0] r;
        r = {1'b0, rem_reg};
        q_bits = '0;
        for (int b = 0; b < RX; b++)
        begin
            r = {r[NW-1:0], work_reg[DW-1-b]};
            if (r >= {1'b0, j_reg})
            begin
                r = r - {1'b0, j_reg};
                q_bits[RX-1-b] = 1'b1;
            end
            else
            begin
                q_bits[RX-1-b] = 1'b0;
            end
        end
        rem_step = r[NW-1:0];
    end

    assign work_shift = {work_reg[DW-RX-1:0], q_bits};
    assign j_dec      = j_reg - NW'(1);
    assign acc_high   = (acc_reg >> bcu_pkg::RESULT_WIDTH) != '0;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        stop_next      = stop_reg;
        ovf_next       = ovf_reg;
        mul_bit_next   = mul_bit_reg;
        div_cnt_next   = div_cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_data_next  = rsp_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    i_next    = req_data.n_total;
                    j_next    = k_eff;
                    stop_next = req_data.n_total - k_eff;
                    ovf_next  = 1'b0;
                    if ({1'b0, req_data.n_total} > bcu_pkg::N_CMP_WIDTH'(bcu_pkg::MAX_N))
                    begin
                        acc_next   = '0;
                        ovf_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else if (req_data.k_chosen > req_data.n_total)
                    begin
                        acc_next   = '0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        acc_next   = AW'(1);
                        state_next = ST_STEP;
                    end
                end
            end

            ST_STEP:
            begin
                // another factor left, or deliver
                if (i_reg > stop_reg)
                begin
                    prod_next    = '0;
                    mul_bit_next = '0;
                    state_next   = ST_MUL;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            ST_MUL:
            begin
                prod_next    = prod_sum;
                mul_bit_next = mul_bit_reg + bcu_pkg::MUL_CNT_WIDTH'(1);
                if (mul_bit_reg == bcu_pkg::MUL_CNT_WIDTH'(bcu_pkg::MUL_BITS - 1))
                begin
                    // commit the wrapped product and flag lost high bits
                    acc_next = prod_sum[AW-1:0];
                    if (prod_sum[PW-1:AW] != '0)
                    begin
                        ovf_next = 1'b1;
                    end
                    i_next = i_reg - NW'(1);
                    if (j_reg != '0)
                    begin
                        work_next    = DW'(prod_sum[AW-1:0]);
                        rem_next     = '0;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_STEP;
                    end
                end
            end

            ST_DIV:
            begin
                work_next    = work_shift;
                rem_next     = rem_step;
                div_cnt_next = div_cnt_reg + bcu_pkg::DIV_CNT_WIDTH'(1);
                if (div_cnt_reg == bcu_pkg::DIV_CNT_WIDTH'(bcu_pkg::DIV_CYCLES - 1))
                begin
                    if (rem_step == '0)
                    begin
                        // exact: take the quotient and try the next divisor
                        acc_next = work_shift[AW-1:0];
                        j_next   = j_dec;
                        if (j_dec != '0)
                        begin
                            work_next    = DW'(work_shift[AW-1:0]);
                            rem_next     = '0;
                            div_cnt_next = '0;
                        end
                        else
                        begin
                            state_next = ST_STEP;
                        end
                    end
                    else
                    begin
                        state_next = ST_STEP;
                    end
                end
            end

            ST_FIN:
            begin
                // hold until the response register is free
                if (rsp_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.coefficient = acc_reg[bcu_pkg::RESULT_WIDTH-1:0];
                    rsp_data_next.overflow    = ovf_reg || acc_high;
                    state_next                = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        stop_reg     <= stop_next;
        ovf_reg      <= ovf_next;
        mul_bit_reg  <= mul_bit_next;
        div_cnt_reg  <= div_cnt_next;
        rsp_data_reg <= rsp_data_next;
    end

`ifndef SYNTH
    // a division trial never runs with a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> j_reg != '0)
        else $error("division trial with zero divisor");

    // the running remainder stays below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < j_reg)
        else $error("divider remainder not below divisor");

    // the multiplier bit counter never passes the factor width
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |->
            mul_bit_reg <= bcu_pkg::MUL_CNT_WIDTH'(bcu_pkg::MUL_BITS - 1))
        else $error("multiplier bit counter out of range");

    // an accepted request starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg != ST_IDLE)
        else $error("accepted request did not start");

    // a new response only comes out of the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == ST_FIN)
        else $error("response raised outside finish step");
`endif

endmodule

// ===== tb/binomial_coefficient_unit_tb.sv =====
// Self-checking testbench for the binomial coefficient unit: directed and
// random (n, k) requests, random idling on both channels, in-order checking.
// Depends on bcu_pkg and binomial_coefficient_unit.
module binomial_coefficient_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 480;
    localparam int QUIET_TAIL     = 60;
    localparam int STALL_LIMIT    = 20000;
    localparam int DRAIN_CYCLES   = 1300;
    localparam int REPORT_LIMIT   = 10;

    // Expected coefficients in request order, with the arithmetic that forms them
    class coefficient_ledger_t;
        bcu_pkg::rsp_t expected_coefficients[$];
        int            failures;
        int            checked;
        int            requests;
        int            k_above_n;
        int            widest;

        function new();
            failures  = 0;
            checked   = 0;
            requests  = 0;
            k_above_n = 0;
            widest    = 0;
        endfunction

        // Multiply by n, n-1, ... and divide by the falling divisor while exact
        function bcu_pkg::rsp_t choose_count(bcu_pkg::req_t item);
            bcu_pkg::rsp_t                    answer;
            logic [bcu_pkg::ACC_WIDTH-1:0]    acc;
            logic [bcu_pkg::PROD_WIDTH-1:0]   prod;
            int                               n;
            int                               k;
            int                               j;
            int                               i;
            bit                               ovf;
            n   = int'(item.n_total);
            k   = int'(item.k_chosen);
            ovf = 1'b0;
            answer = '0;
            if (n > bcu_pkg::MAX_N)
            begin
                answer.overflow = 1'b1;
                return answer;
            end
            if (k > n)
                return answer;
            if (n - k < k)
                k = n - k;
            acc = bcu_pkg::ACC_WIDTH'(1);
            j   = k;
            for (i = n; i > n - k; i--)
            begin
                prod = bcu_pkg::PROD_WIDTH'(acc) * bcu_pkg::PROD_WIDTH'(i);
                if (|prod[bcu_pkg::PROD_WIDTH-1:bcu_pkg::ACC_WIDTH])
                    ovf = 1'b1;
                acc = prod[bcu_pkg::ACC_WIDTH-1:0];
                while (j > 0 && (acc % bcu_pkg::ACC_WIDTH'(j)) == 0)
                begin
                    acc = acc / bcu_pkg::ACC_WIDTH'(j);
                    j--;
                end
            end
            if (|acc[bcu_pkg::ACC_WIDTH-1:bcu_pkg::RESULT_WIDTH])
                ovf = 1'b1;
            answer.coefficient = acc[bcu_pkg::RESULT_WIDTH-1:0];
            answer.overflow    = ovf;
            return answer;
        endfunction

        function void note_request(bcu_pkg::req_t item);
            expected_coefficients = {expected_coefficients, choose_count(item)};
            requests++;
            if (item.k_chosen > item.n_total)
                k_above_n++;
            if (item.n_total == bcu_pkg::N_WIDTH'(bcu_pkg::MAX_N))
                widest++;
        endfunction

        function void check_response(bcu_pkg::rsp_t actual);
            bcu_pkg::rsp_t want;
            checked++;
            if (expected_coefficients.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected response: coefficient %0d overflow %0b",
                             actual.coefficient, actual.overflow);
                return;
            end
            want = expected_coefficients.pop_front();
            if (actual.coefficient !== want.coefficient
                    || actual.overflow !== want.overflow)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"response %0d: coefficient exp %0d got %0d, ",
                              "overflow exp %0b got %0b"},
                             checked, want.coefficient, actual.coefficient,
                             want.overflow, actual.overflow);
            end
        endfunction

        function int pending();
            return expected_coefficients.size();
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    bcu_pkg::req_t   req_data;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    bcu_pkg::rsp_t   rsp_data;

    coefficient_ledger_t ledger;
    int                  idle_pct = 20;
    int                  stall_left = 0;
    int                  idle_cycles = 0;

    binomial_coefficient_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hold off the response channel in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if ($urandom_range(99) < idle_pct)
            stall_left = $urandom_range(1, 8);
        rsp_stall <= (stall_left > 0);
    end

    // Check every response transfer
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            ledger.check_response(rsp_data);
    end

    // Stop the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, ledger.pending());
            $display("binomial_coefficient_unit_tb: FAIL");
            $finish;
        end
    end

    // Offer one request, after an optional gap, and hold it until the transfer
    task automatic send_request(input bcu_pkg::req_t item);
        if ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        ledger.note_request(item);
    endtask

    task automatic send_pair(input int n, input int k);
        bcu_pkg::req_t item;
        item.n_total  = bcu_pkg::N_WIDTH'(n);
        item.k_chosen = bcu_pkg::N_WIDTH'(k);
        send_request(item);
    endtask

    initial
    begin
        int idx;
        int n;
        int k;
        int pct_choice[4];
        pct_choice = '{0, 10, 30, 60};
        ledger     = new();
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_data   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, k above n, k zero and k equal to n, widest results
        send_pair(0, 0);
        send_pair(63, 63);
        send_pair(63, 0);
        send_pair(0, 63);
        send_pair(5, 6);
        send_pair(62, 63);
        send_pair(1, 0);
        send_pair(1, 1);
        send_pair(63, 1);
        send_pair(63, 62);
        send_pair(63, 31);
        send_pair(63, 32);
        send_pair(62, 31);
        send_pair(61, 30);
        send_pair(50, 25);
        send_pair(40, 20);
        send_pair(10, 5);
        send_pair(7, 3);
        send_pair(42, 21);
        send_pair(21, 42);

        // Random: mostly k within range, some k above n; vary idling by phase
        for (idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            if (idx % 60 == 0)
                idle_pct = pct_choice[$urandom_range(0, 3)];
            if (idx >= RANDOM_ITEMS - QUIET_TAIL)
                idle_pct = 0;
            n = $urandom_range(0, 63);
            if ($urandom_range(99) < 40)
                k = $urandom_range(0, 63);
            else if ($urandom_range(99) < 30)
                k = $urandom_range(0, (n < 4) ? n : 4);
            else
                k = $urandom_range(0, n);
            send_pair(n, k);
        end
        req_valid <= 1'b0;

        // Drain outstanding responses, then watch for stray ones
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d with k above n, %0d with n at its maximum)",
                 ledger.requests, ledger.k_above_n, ledger.widest);
        $display("checked %0d responses, %0d mismatches", ledger.checked, ledger.failures);
        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("binomial_coefficient_unit_tb: PASS");
        else
            $display("binomial_coefficient_unit_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/bcu_pkg.sv
src/binomial_coefficient_unit.sv
tb/binomial_coefficient_unit_tb.sv
